// File: sv/i2c_master_byte_sequencer_unit_defines.svh
// assertion macros for the i2c byte sequencer
`ifndef I2C_MASTER_BYTE_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ibs assertion failed");

// antecedent implies consequent in the next cycle
`define IBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ibs assertion failed");

`endif

// File: sv/ibs_pkg.sv
// types, constants and phase table of the i2c byte sequencer
`timescale 1ns / 1ps
`default_nettype none

package ibs_pkg;

  localparam int unsigned DelayWidthDefault = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned ApbAddrWidth = 3;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_QUARTER = 1'b0,
    REG_HALF    = 1'b1
  } reg_e;

  typedef enum logic [4:0] {
    PH_S_SDA_REL      = 5'd0,
    PH_S_SCL_REL      = 5'd1,
    PH_S_SDA_PULL     = 5'd2,
    PH_S_SCL_PULL     = 5'd3,
    PH_P_SCL_REL      = 5'd4,
    PH_P_SDA_REL      = 5'd5,
    PH_W_DATA         = 5'd6,
    PH_W_SCL_REL      = 5'd7,
    PH_W_SCL_PULL     = 5'd8,
    PH_W_SDA_REL      = 5'd9,
    PH_W_ACK_SCL_REL  = 5'd10,
    PH_W_ACK_SAMPLE   = 5'd11,
    PH_W_ACK_SCL_PULL = 5'd12,
    PH_W_SDA_PULL     = 5'd13,
    PH_R_SDA_REL      = 5'd14,
    PH_R_SCL_REL      = 5'd15,
    PH_R_SAMPLE       = 5'd16,
    PH_R_ACK_DRIVE    = 5'd17,
    PH_R_ACK_SCL_REL  = 5'd18,
    PH_R_SCL_PULL     = 5'd19,
    PH_IDLE           = 5'd31
  } phase_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_byte;
    logic       give_ack;
    logic       sda_sense;
  } in_word_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       finished;
    logic [7:0] read_byte;
    logic       ack_seen;
  } out_word_t;

  typedef struct packed {
    logic [7:0] quarter_ticks;
    logic [7:0] half_ticks;
  } cfg_t;

  // classified tick held in the queue
  typedef struct packed {
    logic       cmd_valid;
    cmd_e       cmd;
    logic [7:0] write_byte;
    logic       give_ack;
    logic       sda_sense;
  } item_t;

  // long delay phases use half_ticks, the rest quarter_ticks
  function automatic logic phase_is_long(phase_e p);
    return p inside {PH_S_SCL_REL, PH_S_SDA_PULL, PH_S_SCL_PULL, PH_P_SCL_REL,
                     PH_P_SDA_REL, PH_W_SCL_PULL, PH_R_SCL_REL, PH_R_SAMPLE,
                     PH_R_SCL_PULL};
  endfunction

endpackage

`default_nettype wire

// File: sv/i2c_master_byte_sequencer_unit.sv
// top level of the i2c byte sequencer
//
//  channel  direction  handshake                   word
//  in       input      in_valid_i / in_ready_o     ibs_pkg::in_word_t
//  out      output     out_valid_o / out_ready_i   ibs_pkg::out_word_t
//  cfg      input      psel/penable/pwrite/pready  quarter_ticks, half_ticks
//
// one word in, one word out; a word can be taken every cycle while the input queue is not full
// a word passes through the input queue and then the registered sequencer output
// each word drives one sequencer step (delay count and phase action)
// reset clears queue, sequencer and output valid flag; no clearing pass
// a stalled output holds its word while the two-entry queue keeps taking input until full
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_byte_sequencer_unit_defines.svh"

module i2c_master_byte_sequencer_unit #(
  parameter int unsigned DELAY_WIDTH = ibs_pkg::DelayWidthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire ibs_pkg::in_word_t                 in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output ibs_pkg::out_word_t                     out_data_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ibs_pkg::ApbAddrWidth-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  ibs_pkg::cfg_t  cfg;
  ibs_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign pready = 1'b1;

  ibs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  ibs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  ibs_back #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `IBS_ASSERT_IMP(a_done_not_busy, out_valid_o && out_data_o.finished, !out_data_o.busy_res)
  `IBS_ASSERT_NEXT(a_pop_loads_out, q_pop, out_valid_o)
  `IBS_ASSERT_IMP(a_empty_takes_input, !q_valid, in_ready_o)

endmodule

`default_nettype wire

// File: sv/ibs_regs.sv
// apb configuration registers of the i2c byte sequencer
`timescale 1ns / 1ps
`default_nettype none

module ibs_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ibs_pkg::ApbAddrWidth-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output ibs_pkg::cfg_t                          cfg_o
);

  ibs_pkg::cfg_t cfg_q;
  ibs_pkg::cfg_t cfg_d;
  ibs_pkg::reg_e sel;
  logic          wr_en;

  assign sel   = ibs_pkg::reg_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        ibs_pkg::REG_QUARTER: cfg_d.quarter_ticks = pwdata[7:0];
        ibs_pkg::REG_HALF:    cfg_d.half_ticks    = pwdata[7:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quarter_ticks <= 8'd3;
      cfg_q.half_ticks    <= 8'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (sel)
      ibs_pkg::REG_QUARTER: prdata = {24'd0, cfg_q.quarter_ticks};
      ibs_pkg::REG_HALF:    prdata = {24'd0, cfg_q.half_ticks};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/ibs_front.sv
// input side: classifies each tick and queues it for the sequencer
`timescale 1ns / 1ps
`default_nettype none

module ibs_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ibs_pkg::in_word_t in_data_i,
  output logic                   q_valid_o,
  output ibs_pkg::item_t         q_item_o,
  input  wire logic              q_pop_i
);

  localparam int unsigned Depth = ibs_pkg::QueueDepth;
  localparam int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw    = $clog2(Depth + 1);

  ibs_pkg::item_t mem_q [Depth];
  ibs_pkg::item_t item;
  logic [Aw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [Aw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [Cw-1:0]  count_q, count_d;
  logic           push;
  logic           pop;

  // command decode, unused codes count as no command
  always_comb begin
    item.cmd_valid  = 1'b1;
    item.cmd        = ibs_pkg::CMD_START;
    item.write_byte = in_data_i.write_byte;
    item.give_ack   = in_data_i.give_ack;
    item.sda_sense  = in_data_i.sda_sense;
    case (ibs_pkg::op_e'(in_data_i.operation))
      ibs_pkg::OP_START: item.cmd = ibs_pkg::CMD_START;
      ibs_pkg::OP_STOP:  item.cmd = ibs_pkg::CMD_STOP;
      ibs_pkg::OP_WRITE: item.cmd = ibs_pkg::CMD_WRITE;
      ibs_pkg::OP_READ:  item.cmd = ibs_pkg::CMD_READ;
      default:           item.cmd_valid = 1'b0;
    endcase
  end

  assign in_ready_o = (count_q != Cw'(Depth));
  assign q_valid_o  = (count_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == Aw'(Depth - 1)) ? '0 : wr_ptr_q + Aw'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == Aw'(Depth - 1)) ? '0 : rd_ptr_q + Aw'(1);
    end
    if (push && !pop) begin
      count_d = count_q + Cw'(1);
    end else if (pop && !push) begin
      count_d = count_q - Cw'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

// File: sv/ibs_back.sv
// bus side: phase sequencer, delay counter and output register
`timescale 1ns / 1ps
`default_nettype none

module ibs_back #(
  parameter int unsigned DELAY_WIDTH = ibs_pkg::DelayWidthDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ibs_pkg::cfg_t  cfg_i,
  input  wire logic           q_valid_i,
  input  wire ibs_pkg::item_t q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ibs_pkg::out_word_t  out_data_o
);

  ibs_pkg::phase_e    phase_q, phase_d;
  logic [3:0]         bit_idx_q, bit_idx_d;
  logic [DELAY_WIDTH-1:0] delay_q, delay_d;
  logic [7:0]         shift_q, shift_d;
  logic               ack_wanted_q, ack_wanted_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               ack_flag_q, ack_flag_d;
  logic [7:0]         last_read_q, last_read_d;
  logic               done;
  ibs_pkg::phase_e    next_ph;
  logic               out_valid_q;
  ibs_pkg::out_word_t out_q, out_d;

  // phase length, saturated to the counter and never zero
  function automatic logic [DELAY_WIDTH-1:0] delay_for(ibs_pkg::phase_e p,
                                                       ibs_pkg::cfg_t c);
    logic [15:0] v;
    logic [15:0] maxv;
    v    = {8'd0, ibs_pkg::phase_is_long(p) ? c.half_ticks : c.quarter_ticks};
    maxv = 16'((32'd1 << DELAY_WIDTH) - 32'd1);
    if (v > maxv) begin
      v = maxv;
    end
    if (v == 16'd0) begin
      v = 16'd1;
    end
    return v[DELAY_WIDTH-1:0];
  endfunction

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d      = phase_q;
    bit_idx_d    = bit_idx_q;
    delay_d      = delay_q;
    shift_d      = shift_q;
    ack_wanted_d = ack_wanted_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    ack_flag_d   = ack_flag_q;
    last_read_d  = last_read_q;
    done         = 1'b0;
    next_ph      = ibs_pkg::PH_IDLE;

    // command pickup while idle
    if (phase_q == ibs_pkg::PH_IDLE && q_item_i.cmd_valid) begin
      bit_idx_d = 4'd0;
      case (q_item_i.cmd)
        ibs_pkg::CMD_START: phase_d = ibs_pkg::PH_S_SDA_REL;
        ibs_pkg::CMD_STOP:  phase_d = ibs_pkg::PH_P_SCL_REL;
        ibs_pkg::CMD_WRITE: begin
          phase_d = ibs_pkg::PH_W_DATA;
          shift_d = q_item_i.write_byte;
        end
        ibs_pkg::CMD_READ: begin
          phase_d      = ibs_pkg::PH_R_SDA_REL;
          shift_d      = 8'd0;
          ack_wanted_d = q_item_i.give_ack;
        end
        default: phase_d = ibs_pkg::PH_IDLE;
      endcase
      delay_d = delay_for(phase_d, cfg_i);
    end

    if (phase_d != ibs_pkg::PH_IDLE) begin
      delay_d = delay_d - DELAY_WIDTH'(1);
      if (delay_d == '0) begin
        case (phase_d)
          ibs_pkg::PH_S_SDA_REL:  begin sda_d = 1'b0; next_ph = ibs_pkg::PH_S_SCL_REL; end
          ibs_pkg::PH_S_SCL_REL:  begin scl_d = 1'b0; next_ph = ibs_pkg::PH_S_SDA_PULL; end
          ibs_pkg::PH_S_SDA_PULL: begin sda_d = 1'b1; next_ph = ibs_pkg::PH_S_SCL_PULL; end
          ibs_pkg::PH_S_SCL_PULL: begin scl_d = 1'b1; next_ph = ibs_pkg::PH_IDLE; end
          ibs_pkg::PH_P_SCL_REL:  begin scl_d = 1'b0; next_ph = ibs_pkg::PH_P_SDA_REL; end
          ibs_pkg::PH_P_SDA_REL:  begin sda_d = 1'b0; next_ph = ibs_pkg::PH_IDLE; end
          ibs_pkg::PH_W_DATA: begin
            sda_d   = !shift_d[7];
            next_ph = ibs_pkg::PH_W_SCL_REL;
          end
          ibs_pkg::PH_W_SCL_REL:  begin scl_d = 1'b0; next_ph = ibs_pkg::PH_W_SCL_PULL; end
          ibs_pkg::PH_W_SCL_PULL: begin
            scl_d     = 1'b1;
            shift_d   = {shift_d[6:0], 1'b0};
            bit_idx_d = bit_idx_d + 4'd1;
            next_ph   = (bit_idx_d < 4'd8) ? ibs_pkg::PH_W_DATA : ibs_pkg::PH_W_SDA_REL;
          end
          ibs_pkg::PH_W_SDA_REL:     begin sda_d = 1'b0; next_ph = ibs_pkg::PH_W_ACK_SCL_REL; end
          ibs_pkg::PH_W_ACK_SCL_REL: begin scl_d = 1'b0; next_ph = ibs_pkg::PH_W_ACK_SAMPLE; end
          ibs_pkg::PH_W_ACK_SAMPLE: begin
            ack_flag_d = !q_item_i.sda_sense;
            next_ph    = ibs_pkg::PH_W_ACK_SCL_PULL;
          end
          ibs_pkg::PH_W_ACK_SCL_PULL: begin scl_d = 1'b1; next_ph = ibs_pkg::PH_W_SDA_PULL; end
          ibs_pkg::PH_W_SDA_PULL:     begin sda_d = 1'b1; next_ph = ibs_pkg::PH_IDLE; end
          ibs_pkg::PH_R_SDA_REL:      begin sda_d = 1'b0; next_ph = ibs_pkg::PH_R_SCL_REL; end
          ibs_pkg::PH_R_SCL_REL: begin
            shift_d = {shift_d[6:0], 1'b0};
            scl_d   = 1'b0;
            next_ph = ibs_pkg::PH_R_SAMPLE;
          end
          ibs_pkg::PH_R_SAMPLE: begin
            shift_d[0] = shift_d[0] | q_item_i.sda_sense;
            scl_d      = 1'b1;
            bit_idx_d  = bit_idx_d + 4'd1;
            next_ph    = (bit_idx_d < 4'd8) ? ibs_pkg::PH_R_SCL_REL : ibs_pkg::PH_R_ACK_DRIVE;
          end
          ibs_pkg::PH_R_ACK_DRIVE: begin
            if (ack_wanted_d) begin
              sda_d = 1'b1;
            end
            next_ph = ibs_pkg::PH_R_ACK_SCL_REL;
          end
          ibs_pkg::PH_R_ACK_SCL_REL: begin scl_d = 1'b0; next_ph = ibs_pkg::PH_R_SCL_PULL; end
          ibs_pkg::PH_R_SCL_PULL: begin
            scl_d       = 1'b1;
            last_read_d = shift_d;
            next_ph     = ibs_pkg::PH_IDLE;
          end
          default: next_ph = ibs_pkg::PH_IDLE;
        endcase
        if (next_ph == ibs_pkg::PH_IDLE) begin
          done    = 1'b1;
          phase_d = ibs_pkg::PH_IDLE;
        end else begin
          phase_d = next_ph;
          delay_d = delay_for(next_ph, cfg_i);
        end
      end
    end

    out_d.scl_pull_low = scl_d;
    out_d.sda_pull_low = sda_d;
    out_d.busy_res     = (phase_d != ibs_pkg::PH_IDLE);
    out_d.finished     = done;
    out_d.read_byte    = last_read_d;
    out_d.ack_seen     = ack_flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= ibs_pkg::PH_IDLE;
      bit_idx_q    <= 4'd0;
      delay_q      <= '0;
      shift_q      <= 8'd0;
      ack_wanted_q <= 1'b0;
      scl_q        <= 1'b0;
      sda_q        <= 1'b0;
      ack_flag_q   <= 1'b0;
      last_read_q  <= 8'd0;
    end else if (q_pop_o) begin
      phase_q      <= phase_d;
      bit_idx_q    <= bit_idx_d;
      delay_q      <= delay_d;
      shift_q      <= shift_d;
      ack_wanted_q <= ack_wanted_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      ack_flag_q   <= ack_flag_d;
      last_read_q  <= last_read_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
